// File: rtl/smss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the slab momentum swap selector.
// No dependencies; imported by every other file of the block.
package smss_pkg;

   localparam int MAX_PARTICLES = 65536;
   localparam int CNT_W         = 16;
   localparam int IDX_W         = 16;
   localparam int DATA_W        = 32;
   localparam int WIDE_W        = 64;
   localparam int CSR_IDX_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_HIGH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_HIGH = 2'd3;

   localparam logic [DATA_W-1:0] LOWER_LOW_RST   = 32'd0;
   localparam logic [DATA_W-1:0] LOWER_HIGH_RST  = 32'd65536;
   localparam logic [DATA_W-1:0] MIDDLE_LOW_RST  = 32'd131072;
   localparam logic [DATA_W-1:0] MIDDLE_HIGH_RST = 32'd196608;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PARTICLES - 1);

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

   // chosen pair at end of scan; fields are zero when no swap
   typedef struct packed {
      logic                     swap;
      logic [IDX_W-1:0]         first_index;
      logic [IDX_W-1:0]         second_index;
      logic signed [DATA_W-1:0] first_vx;
      logic signed [DATA_W-1:0] second_vx;
      logic [DATA_W-1:0]        first_mass;
      logic [DATA_W-1:0]        first_mag;
      logic [DATA_W-1:0]        second_mass;
      logic [DATA_W-1:0]        second_mag;
   } smss_pick_type;

endpackage

// File: rtl/smss_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for particle requests and swap responses.
// Depends on smss_pkg.
interface smss_req_if;
   import smss_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [DATA_W-1:0]        y_pos;
   logic signed [DATA_W-1:0] vel_x;
   logic [DATA_W-1:0]        mass;
   logic                     last;

   modport source (output valid, y_pos, vel_x, mass, last, input ready);
   modport sink   (input valid, y_pos, vel_x, mass, last, output ready);
endinterface

interface smss_rsp_if;
   import smss_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     swap_done;
   logic [IDX_W-1:0]         first_index;
   logic [IDX_W-1:0]         second_index;
   logic signed [DATA_W-1:0] first_new_vx;
   logic signed [DATA_W-1:0] second_new_vx;
   logic signed [WIDE_W-1:0] momentum_delta;
   logic signed [WIDE_W-1:0] momentum_total;

   modport source (output valid, swap_done, first_index, second_index, first_new_vx,
                   second_new_vx, momentum_delta, momentum_total, input ready);
   modport sink   (input valid, swap_done, first_index, second_index, first_new_vx,
                   second_new_vx, momentum_delta, momentum_total, output ready);
endinterface

// File: rtl/smss_track.sv
`timescale 1ns / 1ps
// Input register, slab bound registers, particle counter and running best tracking.
// Depends on smss_pkg and smss_req_if; hands the chosen pair to smss_xfer.
module smss_track (
   input  logic                            clock,
   input  logic                            reset,
   smss_req_if.sink                        req_ch,
   input  logic                            csr_we,
   input  logic [smss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smss_pkg::DATA_W-1:0]     csr_wdata,
   output logic                            pick_valid,
   output smss_pkg::smss_pick_type         pick,
   input  logic                            pick_ready
);
   import smss_pkg::*;

   logic [DATA_W-1:0] lo_low_ff, lo_high_ff, mid_low_ff, mid_high_ff;

   logic                     v0_ff, v0_in;
   logic [DATA_W-1:0]        y0_ff;
   logic signed [DATA_W-1:0] vx0_ff;
   logic [DATA_W-1:0]        m0_ff;
   logic                     last0_ff;

   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     pos_found_ff, pos_found_in, neg_found_ff, neg_found_in;
   logic signed [DATA_W-1:0] pos_vx_ff, pos_vx_in, neg_vx_ff, neg_vx_in;
   logic [IDX_W-1:0]         pos_idx_ff, pos_idx_in, neg_idx_ff, neg_idx_in;
   logic [DATA_W-1:0]        pos_m_ff, pos_m_in, neg_m_ff, neg_m_in;

   logic                     fire0, in_low, in_mid, take_pos, take_neg, swap;
   logic [IDX_W-1:0]         idx;
   logic                     pos_found_upd, neg_found_upd;
   logic signed [DATA_W-1:0] pos_vx_upd, neg_vx_upd;
   logic [IDX_W-1:0]         pos_idx_upd, neg_idx_upd;
   logic [DATA_W-1:0]        pos_m_upd, neg_m_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_low_ff   <= LOWER_LOW_RST;
         lo_high_ff  <= LOWER_HIGH_RST;
         mid_low_ff  <= MIDDLE_LOW_RST;
         mid_high_ff <= MIDDLE_HIGH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOWER_LOW:   lo_low_ff   <= csr_wdata;
            CSR_LOWER_HIGH:  lo_high_ff  <= csr_wdata;
            CSR_MIDDLE_LOW:  mid_low_ff  <= csr_wdata;
            CSR_MIDDLE_HIGH: mid_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a last item waits here until the result pipe can take it
   assign fire0        = v0_ff && (!last0_ff || pick_ready);
   assign req_ch.ready = !v0_ff || fire0;
   assign v0_in        = req_ch.ready ? req_ch.valid : v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         y0_ff    <= req_ch.y_pos;
         vx0_ff   <= req_ch.vel_x;
         m0_ff    <= req_ch.mass;
         last0_ff <= req_ch.last;
      end
   end

   assign idx      = cnt_ff[IDX_W-1:0];
   assign in_low   = (y0_ff > lo_low_ff) && (y0_ff < lo_high_ff);
   assign in_mid   = (y0_ff > mid_low_ff) && (y0_ff < mid_high_ff);
   assign take_pos = in_low && (!pos_found_ff || (vx0_ff > pos_vx_ff));
   assign take_neg = in_mid && (!neg_found_ff || (vx0_ff < neg_vx_ff));

   assign pos_found_upd = pos_found_ff || in_low;
   assign pos_vx_upd    = take_pos ? vx0_ff : pos_vx_ff;
   assign pos_idx_upd   = take_pos ? idx    : pos_idx_ff;
   assign pos_m_upd     = take_pos ? m0_ff  : pos_m_ff;
   assign neg_found_upd = neg_found_ff || in_mid;
   assign neg_vx_upd    = take_neg ? vx0_ff : neg_vx_ff;
   assign neg_idx_upd   = take_neg ? idx    : neg_idx_ff;
   assign neg_m_upd     = take_neg ? m0_ff  : neg_m_ff;

   always_comb begin
      cnt_in       = cnt_ff;
      pos_found_in = pos_found_ff;
      pos_vx_in    = pos_vx_ff;
      pos_idx_in   = pos_idx_ff;
      pos_m_in     = pos_m_ff;
      neg_found_in = neg_found_ff;
      neg_vx_in    = neg_vx_ff;
      neg_idx_in   = neg_idx_ff;
      neg_m_in     = neg_m_ff;
      if (fire0) begin
         if (last0_ff) begin
            cnt_in       = '0;
            pos_found_in = 1'b0;
            pos_vx_in    = '0;
            pos_idx_in   = '0;
            pos_m_in     = '0;
            neg_found_in = 1'b0;
            neg_vx_in    = '0;
            neg_idx_in   = '0;
            neg_m_in     = '0;
         end else begin
            cnt_in       = (cnt_ff == CNT_LAST) ? '0 : cnt_ff + 1'b1;
            pos_found_in = pos_found_upd;
            pos_vx_in    = pos_vx_upd;
            pos_idx_in   = pos_idx_upd;
            pos_m_in     = pos_m_upd;
            neg_found_in = neg_found_upd;
            neg_vx_in    = neg_vx_upd;
            neg_idx_in   = neg_idx_upd;
            neg_m_in     = neg_m_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pos_found_ff <= 1'b0;
         pos_vx_ff    <= '0;
         pos_idx_ff   <= '0;
         pos_m_ff     <= '0;
         neg_found_ff <= 1'b0;
         neg_vx_ff    <= '0;
         neg_idx_ff   <= '0;
         neg_m_ff     <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         pos_found_ff <= pos_found_in;
         pos_vx_ff    <= pos_vx_in;
         pos_idx_ff   <= pos_idx_in;
         pos_m_ff     <= pos_m_in;
         neg_found_ff <= neg_found_in;
         neg_vx_ff    <= neg_vx_in;
         neg_idx_ff   <= neg_idx_in;
         neg_m_ff     <= neg_m_in;
      end
   end

   assign swap = pos_found_upd && neg_found_upd && (pos_vx_upd > 0) && (neg_vx_upd < 0);

   assign pick_valid        = v0_ff && last0_ff;
   assign pick.swap         = swap;
   assign pick.first_index  = swap ? pos_idx_upd : '0;
   assign pick.second_index = swap ? neg_idx_upd : '0;
   assign pick.first_vx     = swap ? pos_vx_upd  : '0;
   assign pick.second_vx    = swap ? neg_vx_upd  : '0;
   assign pick.first_mass   = swap ? pos_m_upd   : '0;
   assign pick.first_mag    = swap ? pos_vx_upd  : '0;
   assign pick.second_mass  = swap ? neg_m_upd   : '0;
   assign pick.second_mag   = swap ? -neg_vx_upd : '0;

endmodule

// File: rtl/smss_xfer.sv
`timescale 1ns / 1ps
// Momentum transfer pipe: pair register, products, saturated sum, running total, output.
// Depends on smss_pkg and smss_rsp_if; fed by smss_track.
module smss_xfer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pick_valid,
   input  smss_pkg::smss_pick_type pick,
   output logic                    pick_ready,
   smss_rsp_if.source              rsp_ch
);
   import smss_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic take1, take2, take3, take4, adv1, adv2, adv3;

   smss_pick_type pick1_ff;

   logic                     swap2_ff, swap3_ff, swap4_ff;
   logic [IDX_W-1:0]         idx1_2_ff, idx2_2_ff, idx1_3_ff, idx2_3_ff, idx1_4_ff, idx2_4_ff;
   logic signed [DATA_W-1:0] vx1_2_ff, vx2_2_ff, vx1_3_ff, vx2_3_ff, vx1_4_ff, vx2_4_ff;
   logic [WIDE_W-1:0]        prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic [WIDE_W:0]          sum;
   logic signed [WIDE_W-1:0] delta3_ff, delta3_in, last_xfer_ff;
   logic signed [WIDE_W-1:0] delta4_ff, total_ff, total_in, total4_ff;
   logic signed [WIDE_W:0]   tot_sum;

   assign take4 = !v4_ff || rsp_ch.ready;
   assign adv3  = v3_ff && take4;
   assign take3 = !v3_ff || adv3;
   assign adv2  = v2_ff && take3;
   assign take2 = !v2_ff || adv2;
   assign adv1  = v1_ff && take2;
   assign take1 = !v1_ff || adv1;
   assign pick_ready = take1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= pick_valid;
         if (take2) v2_ff <= adv1;
         if (take3) v3_ff <= adv2;
         if (take4) v4_ff <= adv3;
      end
   end

   always_ff @(posedge clock) begin
      if (take1 && pick_valid) begin
         pick1_ff <= pick;
      end
   end

   assign prod1_in = pick1_ff.first_mass * pick1_ff.first_mag;
   assign prod2_in = pick1_ff.second_mass * pick1_ff.second_mag;

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod1_ff  <= prod1_in;
         prod2_ff  <= prod2_in;
         swap2_ff  <= pick1_ff.swap;
         idx1_2_ff <= pick1_ff.first_index;
         idx2_2_ff <= pick1_ff.second_index;
         vx1_2_ff  <= pick1_ff.second_vx;
         vx2_2_ff  <= pick1_ff.first_vx;
      end
   end

   // each product is below 2^63, so only the positive limit can be hit
   assign sum       = {1'b0, prod1_ff} + {1'b0, prod2_ff};
   assign delta3_in = !swap2_ff ? last_xfer_ff :
                      (sum[WIDE_W:WIDE_W-1] != 2'b00) ? WIDE_MAX : sum[WIDE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_xfer_ff <= '0;
      end else if (adv2) begin
         last_xfer_ff <= delta3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         delta3_ff <= delta3_in;
         swap3_ff  <= swap2_ff;
         idx1_3_ff <= idx1_2_ff;
         idx2_3_ff <= idx2_2_ff;
         vx1_3_ff  <= vx1_2_ff;
         vx2_3_ff  <= vx2_2_ff;
      end
   end

   assign tot_sum  = {total_ff[WIDE_W-1], total_ff} + {delta3_ff[WIDE_W-1], delta3_ff};
   assign total_in = !swap3_ff ? total_ff :
                     (tot_sum[WIDE_W] != tot_sum[WIDE_W-1]) ?
                        (tot_sum[WIDE_W] ? WIDE_MIN : WIDE_MAX) : tot_sum[WIDE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (adv3) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         swap4_ff  <= swap3_ff;
         idx1_4_ff <= idx1_3_ff;
         idx2_4_ff <= idx2_3_ff;
         vx1_4_ff  <= vx1_3_ff;
         vx2_4_ff  <= vx2_3_ff;
         delta4_ff <= delta3_ff;
         total4_ff <= total_in;
      end
   end

   assign rsp_ch.valid          = v4_ff;
   assign rsp_ch.swap_done      = swap4_ff;
   assign rsp_ch.first_index    = idx1_4_ff;
   assign rsp_ch.second_index   = idx2_4_ff;
   assign rsp_ch.first_new_vx   = vx1_4_ff;
   assign rsp_ch.second_new_vx  = vx2_4_ff;
   assign rsp_ch.momentum_delta = delta4_ff;
   assign rsp_ch.momentum_total = total4_ff;

endmodule

// File: rtl/slab_momentum_swap_select.sv
`timescale 1ns / 1ps
// Top level of the slab momentum swap selector.
// Depends on smss_pkg, smss_chan_if, smss_track and smss_xfer.
//
//   port      dir     kind          carries
//   req_ch    in      valid/ready   one particle: y_pos, vel_x, mass, last
//   rsp_ch    out     valid/ready   one swap result per scan, on the last particle
//   csr_*     in      write only    slab bounds, index 0..3
//
// One particle per cycle while no last particle waits on the result pipe; the
// best tracking compare and select is the single-cycle loop. A taken last particle
// passes the input, pair, multiply, saturated sum and total registers in order.
// Reset clears counter, bests, last transfer and total; no clearing pass.
// Stages collapse bubbles, so a stalled rsp_ch only holds back a last particle
// once every stage behind it is full.
module slab_momentum_swap_select (
   input  logic                            clock,
   input  logic                            reset,
   smss_req_if.sink                        req_ch,
   smss_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [smss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smss_pkg::DATA_W-1:0]     csr_wdata
);
   import smss_pkg::*;

   logic          pick_valid;
   logic          pick_ready;
   smss_pick_type pick;

   smss_track u_track (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pick_valid (pick_valid),
      .pick       (pick),
      .pick_ready (pick_ready)
   );

   smss_xfer u_xfer (
      .clock      (clock),
      .reset      (reset),
      .pick_valid (pick_valid),
      .pick       (pick),
      .pick_ready (pick_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
